### hdl/rigk_pkg.sv
// Shared types and constants for the reverse-in-groups block.
`timescale 1ns / 1ps
package rigk_pkg;

  // Default group depth and the upper bound of the parameter's range.
  localparam int MAX_GROUP_DEF = 16;
  localparam int MAX_GROUP_LIM = 64;

  // Field widths sized for the whole parameter range.
  localparam int CNT_MAX_W  = $clog2(MAX_GROUP_LIM + 1);
  localparam int ADDR_MAX_W = $clog2(MAX_GROUP_LIM);

  localparam int VALUE_W = 32;
  localparam int CFG_W   = 5;

  // One closed group, handed from the front to the back.
  typedef struct packed {
    logic                 bank;
    logic [CNT_MAX_W-1:0] count;
    logic                 rev;
    logic                 eol;
  } grp_desc_t;

  // Buffer write from the front.
  typedef struct packed {
    logic                  en;
    logic                  bank;
    logic [ADDR_MAX_W-1:0] addr;
    logic [VALUE_W-1:0]    data;
  } buf_wr_t;

endpackage

### hdl/rigk_front.sv
// Front end: accepts elements, fills the current bank and closes groups.
`timescale 1ns / 1ps
module rigk_front #(
  parameter int MAX_GROUP = rigk_pkg::MAX_GROUP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            value,
  input  logic                          end_of_list,
  input  logic [rigk_pkg::CFG_W-1:0]    group_size,
  input  logic                          q_full,
  output logic                          push,
  output rigk_pkg::grp_desc_t           desc,
  output rigk_pkg::buf_wr_t             wr
);

  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int CW    = rigk_pkg::CNT_MAX_W;

  logic [CNT_W-1:0] fill;
  logic             bank;
  logic             accept;
  logic [CW-1:0]    gs_ext;
  logic [CW-1:0]    size;
  logic [CW-1:0]    n;
  logic             full_grp;
  logic             close;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Clamp the configured size into 1..MAX_GROUP.
  always_comb begin
    gs_ext = CW'(group_size);
    if (gs_ext == '0) begin
      size = CW'(1);
    end else if (gs_ext > CW'(MAX_GROUP)) begin
      size = CW'(MAX_GROUP);
    end else begin
      size = gs_ext;
    end
  end

  assign n        = CW'(fill) + CW'(1);
  assign full_grp = (n >= size);
  assign close    = full_grp || end_of_list;

  always_comb begin
    wr.en   = accept;
    wr.bank = bank;
    wr.addr = rigk_pkg::ADDR_MAX_W'(fill);
    wr.data = value;
    push       = accept && close;
    desc.bank  = bank;
    desc.count = n;
    desc.rev   = full_grp;
    desc.eol   = end_of_list;
  end

  // Advance the fill position, or hand the bank over on a closed group.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bank <= 1'b0;
    end else if (accept) begin
      if (close) begin
        fill <= '0;
        bank <= ~bank;
      end else begin
        fill <= CNT_W'(n);
      end
    end
  end

endmodule

### hdl/rigk_queue.sv
// Two-entry queue of closed-group descriptors between front and back.
`timescale 1ns / 1ps
module rigk_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rigk_pkg::grp_desc_t push_desc,
  input  logic                pop,
  output logic                head_valid,
  output rigk_pkg::grp_desc_t head,
  output logic                full
);

  rigk_pkg::grp_desc_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/rigk_back.sv
// Back end: holds both group banks and drains closed groups to the output.
`timescale 1ns / 1ps
module rigk_back #(
  parameter int MAX_GROUP = rigk_pkg::MAX_GROUP_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rigk_pkg::buf_wr_t   wr,
  input  logic                head_valid,
  input  rigk_pkg::grp_desc_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  value_res,
  output logic                end_of_list_res
);

  localparam int CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [rigk_pkg::VALUE_W-1:0] mem [2][MAX_GROUP];

  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] last_k;
  logic [CNT_W-1:0] rd_pos;
  logic             last;
  logic             load;

  assign cnt    = CNT_W'(head.count);
  assign last_k = cnt - CNT_W'(1);
  assign last   = (k == last_k);
  assign rd_pos = head.rev ? (last_k - k) : k;
  assign load   = head_valid && (!out_valid || !out_stall);
  assign pop    = load && last;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.bank][ADDR_W'(wr.addr)] <= wr.data;
    end
  end

  // Read straight into the output register.
  always_ff @(posedge clk) begin
    if (load) begin
      value_res       <= mem[head.bank][rd_pos[ADDR_W-1:0]];
      end_of_list_res <= head.eol && last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        k <= last ? '0 : k + CNT_W'(1);
      end
    end
  end

endmodule

### hdl/reverse_in_groups_of_k.sv
// Top level of the reverse-in-groups stream reorderer.
`timescale 1ns / 1ps
// Reorders a stream of signed 32-bit list elements in groups of group_size
// (clamped to 1..MAX_GROUP; 0 behaves as 1). A full group leaves reversed as
// soon as its last element is taken; a short final group leaves in arrival
// order when end_of_list arrives, and the last result of a list carries
// end_of_list_res. While in_stall is low, the front takes one element per cycle
// into one of two group banks; when a group closes it hands the bank to the
// back through a two-entry descriptor queue and carries on filling the other
// bank. The back reads one element per cycle from the bank memory straight into
// the output register, so a group of n elements occupies the output for n
// transfers. When the back is idle, a group's first result follows its closing
// transfer via the queue and output registers. Throughput is one element per
// cycle in and out while the output does not stall and groups keep a steady
// length. in_stall rises while both banks hold groups not yet drained: when the
// output side stalls, or when a short group closes while a longer one is still
// draining. Write group_size only while the block is idle.
module reverse_in_groups_of_k #(
  parameter int MAX_GROUP = rigk_pkg::MAX_GROUP_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [rigk_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         value,
  input  logic                       end_of_list,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         value_res,
  output logic                       end_of_list_res
);

  logic [rigk_pkg::CFG_W-1:0] group_size;

  rigk_pkg::grp_desc_t desc;
  rigk_pkg::grp_desc_t head;
  rigk_pkg::buf_wr_t   wr;
  logic                push;
  logic                pop;
  logic                head_valid;
  logic                q_full;

  // Hold the group size register; reset to one, which passes data through.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= rigk_pkg::CFG_W'(1);
    end else if (cfg_write) begin
      group_size <= cfg_data;
    end
  end

  // Front: take elements, fill the current bank, close groups.
  rigk_front #(.MAX_GROUP(MAX_GROUP)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .end_of_list (end_of_list),
    .group_size  (group_size),
    .q_full      (q_full),
    .push        (push),
    .desc        (desc),
    .wr          (wr)
  );

  // Queue: one descriptor per bank awaiting or under drain.
  rigk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (q_full)
  );

  // Back: drain the head group, reversed or in order, one transfer a cycle while the output does not stall.
  rigk_back #(.MAX_GROUP(MAX_GROUP)) u_back (
    .clk             (clk),
    .rst             (rst),
    .wr              (wr),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .value_res       (value_res),
    .end_of_list_res (end_of_list_res)
  );

endmodule
